// File: rtl/infix_to_postfix_converter_macros.svh
// Assertion macros shared by the converter RTL.
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IFP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ifp_pkg.sv
// Shared types, constants and operator tables of the infix to postfix converter.
package ifp_pkg;

  localparam int DEFAULT_STACK_DEPTH = 32;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPZ   = 8'h5A;
  localparam logic [7:0] CH_LOWA  = 8'h61;
  localparam logic [7:0] CH_LOWZ  = 8'h7A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam int OP_CODE_W = 3;

  typedef enum logic [OP_CODE_W-1:0] {
    OP_NONE = 3'd0,
    OP_OPEN = 3'd1,
    OP_ADD  = 3'd2,
    OP_SUB  = 3'd3,
    OP_MUL  = 3'd4,
    OP_DIV  = 3'd5
  } op_code_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNMATCHED = 2'd2,
    ERR_INVALID   = 2'd3
  } err_t;

  typedef struct packed {
    logic [7:0] in_symbol;
    logic       end_of_expression;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       has_symbol;
    logic       last_of_run;
    logic [1:0] error_code;
  } out_item_t;

  function automatic logic [7:0] op_char(input op_code_t code);
    logic [7:0] ch;
    unique case (code)
      OP_OPEN: ch = CH_OPEN;
      OP_ADD:  ch = CH_ADD;
      OP_SUB:  ch = CH_SUB;
      OP_MUL:  ch = CH_MUL;
      OP_DIV:  ch = CH_DIV;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // '(' has the lowest real priority so it stops every pop.
  function automatic logic [1:0] op_prio(input op_code_t code);
    logic [1:0] p;
    unique case (code)
      OP_OPEN:        p = 2'd1;
      OP_ADD, OP_SUB: p = 2'd2;
      OP_MUL, OP_DIV: p = 2'd3;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/ifp_ram.sv
// Generic single write port, single read port RAM with registered read data.
module ifp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/infix_to_postfix_converter.sv
// Shunting-yard infix to postfix converter with the operator stack in RAM.
// A new item is taken only in idle, so the input stalls while an item is worked on. An operator
// or ')' on a non-empty stack pops by a RAM read, then compare and emit, per operator popped.
// The end mark flushes every stacked entry by the same read and emit, dropping an unclosed '(';
// the last result of an item is held until the item ends.
// Synchronous reset clears count and valids, not RAM.
module infix_to_postfix_converter
  #(
    parameter int STACK_DEPTH = ifp_pkg::DEFAULT_STACK_DEPTH
  ) (
    input  logic               clk,
    input  logic               rst,
    input  logic               in_valid,
    output logic               in_stall,
    input  ifp_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ifp_pkg::out_item_t out_data
  );

  import ifp_pkg::*;

  `include "infix_to_postfix_converter_macros.svh"

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_POP,
    ST_FLUSH,
    ST_FLUSH_EVAL,
    ST_FINISH
  } state_t;

  state_t    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] count_dec;
  out_item_t hold, hold_next;
  logic      hold_valid, hold_valid_next;
  out_item_t out_next;
  logic      out_valid_next;

  logic      end_r;
  logic      close_r;
  op_code_t  code_r;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [OP_CODE_W-1:0] wr_data, rd_data;
  op_code_t      top;

  logic      in_accept;
  logic [7:0] sym;
  logic      is_space, is_operand, is_open, is_close;
  op_code_t  in_code;
  logic      full, empty, out_free, can_emit;
  logic      emit;
  out_item_t emit_item;
  state_t    done_in, done_r;

  ifp_ram #(
    .WIDTH(OP_CODE_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign top       = op_code_t'(rd_data);
  assign count_dec = count - CW'(1);
  assign full      = (count == CW'(STACK_DEPTH));
  assign empty     = (count == '0);
  assign out_free  = !out_valid || !out_stall;
  assign can_emit  = !hold_valid || out_free;
  assign done_in   = in_data.end_of_expression ? ST_FLUSH : ST_FINISH;
  assign done_r    = end_r ? ST_FLUSH : ST_FINISH;

  // Character classification after folding lower case to upper case.
  always_comb begin
    sym = in_data.in_symbol;
    if (sym >= CH_LOWA && sym <= CH_LOWZ) begin
      sym = sym - CASE_OFFSET;
    end
    is_space   = (sym == CH_SPACE) || (sym >= CH_TAB && sym <= CH_CR);
    is_operand = (sym >= CH_DIG0 && sym <= CH_DIG9) || (sym >= CH_UPA && sym <= CH_UPZ);
    is_open    = (sym == CH_OPEN);
    is_close   = (sym == CH_CLOSE);
    unique case (sym)
      CH_ADD:  in_code = OP_ADD;
      CH_SUB:  in_code = OP_SUB;
      CH_MUL:  in_code = OP_MUL;
      CH_DIV:  in_code = OP_DIV;
      default: in_code = OP_NONE;
    endcase
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    hold_next       = hold;
    hold_valid_next = hold_valid;
    out_next        = out_data;
    out_valid_next  = out_valid && out_stall;
    rd_en           = 1'b0;
    rd_addr         = count_dec[AW-1:0];
    wr_en           = 1'b0;
    wr_addr         = count[AW-1:0];
    wr_data         = code_r;
    emit            = 1'b0;
    emit_item       = '0;

    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (is_space) begin
            state_next = in_data.end_of_expression ? ST_FLUSH : ST_IDLE;
          end else if (is_operand) begin
            emit       = 1'b1;
            emit_item  = '{out_symbol: sym, has_symbol: 1'b1, last_of_run: 1'b0,
                           error_code: ERR_NONE};
            state_next = done_in;
          end else if (is_open) begin
            if (full) begin
              emit      = 1'b1;
              emit_item.error_code = ERR_OVERFLOW;
            end else begin
              wr_en      = 1'b1;
              wr_data    = OP_OPEN;
              count_next = count + CW'(1);
            end
            state_next = done_in;
          end else if (is_close || in_code != OP_NONE) begin
            if (!empty) begin
              rd_en      = 1'b1;
              state_next = ST_EVAL;
            end else if (is_close) begin
              emit       = 1'b1;
              emit_item.error_code = ERR_UNMATCHED;
              state_next = done_in;
            end else begin
              wr_en      = 1'b1;
              wr_data    = in_code;
              count_next = count + CW'(1);
              state_next = done_in;
            end
          end else begin
            emit       = 1'b1;
            emit_item.error_code = ERR_INVALID;
            state_next = done_in;
          end
        end
      end

      ST_EVAL: begin
        if (close_r && top == OP_OPEN) begin
          count_next = count_dec;
          state_next = done_r;
        end else if (!close_r && op_prio(top) < op_prio(code_r)) begin
          if (!full) begin
            wr_en      = 1'b1;
            count_next = count + CW'(1);
            state_next = done_r;
          end else if (can_emit) begin
            emit       = 1'b1;
            emit_item.error_code = ERR_OVERFLOW;
            state_next = done_r;
          end
        end else if (can_emit) begin
          emit       = 1'b1;
          emit_item  = '{out_symbol: op_char(top), has_symbol: 1'b1, last_of_run: 1'b0,
                         error_code: ERR_NONE};
          count_next = count_dec;
          state_next = ST_POP;
        end
      end

      ST_POP: begin
        if (!empty) begin
          rd_en      = 1'b1;
          state_next = ST_EVAL;
        end else if (!close_r) begin
          // An empty stack always has room for the operator.
          wr_en      = 1'b1;
          count_next = count + CW'(1);
          state_next = done_r;
        end else if (can_emit) begin
          emit       = 1'b1;
          emit_item.error_code = ERR_UNMATCHED;
          state_next = done_r;
        end
      end

      ST_FLUSH: begin
        if (empty) begin
          state_next = ST_FINISH;
        end else begin
          rd_en      = 1'b1;
          state_next = ST_FLUSH_EVAL;
        end
      end

      ST_FLUSH_EVAL: begin
        // An unclosed '(' is dropped without a result.
        if (top == OP_OPEN) begin
          count_next = count_dec;
          state_next = ST_FLUSH;
        end else if (can_emit) begin
          emit       = 1'b1;
          emit_item  = '{out_symbol: op_char(top), has_symbol: 1'b1, last_of_run: 1'b0,
                         error_code: ERR_NONE};
          count_next = count_dec;
          state_next = ST_FLUSH;
        end
      end

      ST_FINISH: begin
        // The held result is the final one of the item, so it can now be marked.
        if (hold_valid) begin
          if (out_free) begin
            out_next             = hold;
            out_next.last_of_run = end_r;
            out_valid_next       = 1'b1;
            hold_valid_next      = 1'b0;
            state_next           = ST_IDLE;
          end
        end else if (end_r) begin
          if (out_free) begin
            out_next             = '0;
            out_next.last_of_run = 1'b1;
            out_valid_next       = 1'b1;
            state_next           = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase

    // A new result pushes the previously held one into the output register.
    if (emit) begin
      if (hold_valid) begin
        out_next       = hold;
        out_valid_next = 1'b1;
      end
      hold_next       = emit_item;
      hold_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      hold_valid <= hold_valid_next;
      out_valid  <= out_valid_next;
    end
    hold     <= hold_next;
    out_data <= out_next;
    if (in_accept) begin
      end_r   <= in_data.end_of_expression;
      close_r <= is_close;
      code_r  <= in_code;
    end
  end

  `IFP_ASSERT_SAME(a_count_bound, 1'b1, count <= CW'(STACK_DEPTH), "stack count past depth")
  `IFP_ASSERT_SAME(a_idle_no_hold, state == ST_IDLE, !hold_valid, "result held while idle")
  `IFP_ASSERT_NEXT(a_operand_held, in_accept && is_operand, hold_valid, "operand result lost")
  `IFP_ASSERT_SAME(a_error_no_symbol, out_valid && out_data.error_code != ERR_NONE,
                   !out_data.has_symbol, "error result carries a symbol")

endmodule

// File: bench/infix_to_postfix_converter_tb.sv
// Self-checking testbench for the streaming infix to postfix converter.
module infix_to_postfix_converter_tb;
  import ifp_pkg::*;

  localparam int STACK_DEPTH = DEFAULT_STACK_DEPTH;
  localparam int RANDOM_ITEMS = 480;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 100;
  localparam int RUN_LIMIT = 4000000;
  localparam int N_ROWS = 26;

  typedef struct packed {
    logic [7:0] sym;
    logic       eoe;
    logic       typed;
    out_item_t  res;
  } stim_row_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  out_item_t   pending_postfix[$];
  out_item_t   symbol_results[$];
  logic [7:0]  infix_text[$];
  logic [7:0]  op_pile[STACK_DEPTH];
  int unsigned pile_size;
  int          mismatches;
  int          random_sent;
  bit          calm;
  bit          hold_request;

  // Rows with typed results only carry a single, obvious result.
  stim_row_t directed_rows[N_ROWS] = '{
    '{CH_CLOSE, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, ERR_UNMATCHED}},
    '{8'h00,    1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, ERR_INVALID}},
    '{8'hFF,    1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, ERR_INVALID}},
    '{CH_SPACE, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ERR_NONE}},
    '{CH_LOWA,  1'b0, 1'b1, '{CH_UPA, 1'b1, 1'b0, ERR_NONE}},
    '{CH_LOWZ,  1'b0, 1'b1, '{CH_UPZ, 1'b1, 1'b0, ERR_NONE}},
    '{CH_DIG0,  1'b0, 1'b1, '{CH_DIG0, 1'b1, 1'b0, ERR_NONE}},
    '{CH_DIG9,  1'b1, 1'b1, '{CH_DIG9, 1'b1, 1'b1, ERR_NONE}},
    '{CH_OPEN,  1'b0, 1'b0, '0},
    '{CH_UPA,   1'b0, 1'b0, '0},
    '{CH_ADD,   1'b0, 1'b0, '0},
    '{"b",      1'b0, 1'b0, '0},
    '{CH_MUL,   1'b0, 1'b0, '0},
    '{CH_TAB,   1'b0, 1'b0, '0},
    '{CH_DIG9,  1'b0, 1'b0, '0},
    '{CH_CLOSE, 1'b0, 1'b0, '0},
    '{CH_SUB,   1'b0, 1'b0, '0},
    '{8'h0A,    1'b0, 1'b0, '0},
    '{"c",      1'b0, 1'b0, '0},
    '{CH_DIV,   1'b0, 1'b0, '0},
    '{8'h0B,    1'b0, 1'b0, '0},
    '{CH_OPEN,  1'b0, 1'b0, '0},
    '{8'h0C,    1'b0, 1'b0, '0},
    '{"D",      1'b0, 1'b0, '0},
    '{CH_CR,    1'b1, 1'b0, '0},
    '{"@",      1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ERR_INVALID}}
  };

  infix_to_postfix_converter #(.STACK_DEPTH(STACK_DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #RUN_LIMIT;
    $display("Some tests failed");
    $finish;
  end

  function automatic void emit_postfix(input logic [7:0] sym, input logic has,
                                       input err_t err);
    out_item_t r;
    r.out_symbol = sym;
    r.has_symbol = has;
    r.last_of_run = 1'b0;
    r.error_code = err;
    symbol_results.push_back(r);
  endfunction

  function automatic bit is_high_rank(input logic [7:0] op);
    return op == CH_MUL || op == CH_DIV;
  endfunction

  function automatic void push_pile(input logic [7:0] op);
    if (pile_size >= STACK_DEPTH) begin
      emit_postfix(8'h00, 1'b0, ERR_OVERFLOW);
    end else begin
      op_pile[pile_size] = op;
      pile_size++;
    end
  endfunction

  // Operators are kept on the pile as their own characters.
  function automatic void shunt_symbol(input in_item_t it);
    logic [7:0] c;
    logic [7:0] top;
    bit         found;
    out_item_t  tail;
    symbol_results.delete();
    c = it.in_symbol;
    if (c >= CH_LOWA && c <= CH_LOWZ) c = c - CASE_OFFSET;
    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
    end else if ((c >= CH_DIG0 && c <= CH_DIG9) || (c >= CH_UPA && c <= CH_UPZ)) begin
      emit_postfix(c, 1'b1, ERR_NONE);
    end else if (c == CH_OPEN) begin
      push_pile(c);
    end else if (c == CH_CLOSE) begin
      found = 1'b0;
      while (!found && pile_size > 0) begin
        pile_size--;
        top = op_pile[pile_size];
        if (top == CH_OPEN) found = 1'b1;
        else emit_postfix(top, 1'b1, ERR_NONE);
      end
      if (!found) emit_postfix(8'h00, 1'b0, ERR_UNMATCHED);
    end else if (c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV) begin
      // Pop while the top binds at least as tightly; an open paren never pops.
      while (pile_size > 0 && op_pile[pile_size-1] != CH_OPEN &&
             (is_high_rank(op_pile[pile_size-1]) || !is_high_rank(c))) begin
        pile_size--;
        emit_postfix(op_pile[pile_size], 1'b1, ERR_NONE);
      end
      push_pile(c);
    end else begin
      emit_postfix(8'h00, 1'b0, ERR_INVALID);
    end
    if (it.end_of_expression) begin
      while (pile_size > 0) begin
        pile_size--;
        if (op_pile[pile_size] != CH_OPEN) emit_postfix(op_pile[pile_size], 1'b1, ERR_NONE);
      end
      if (symbol_results.size() == 0) emit_postfix(8'h00, 1'b0, ERR_NONE);
      tail = symbol_results.pop_back();
      tail.last_of_run = 1'b1;
      symbol_results.push_back(tail);
    end
  endfunction

  task automatic offer(input logic [7:0] sym, input logic eoe, input logic typed,
                       input out_item_t typed_res);
    in_item_t it;
    it.in_symbol = sym;
    it.end_of_expression = eoe;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    shunt_symbol(it);
    if (typed) pending_postfix.push_back(typed_res);
    else foreach (symbol_results[i]) pending_postfix.push_back(symbol_results[i]);
    random_sent++;
    if (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] random_operand();
    case ($urandom_range(2))
      0: return CH_DIG0 + 8'($urandom_range(9));
      1: return CH_UPA + 8'($urandom_range(25));
      default: return CH_LOWA + 8'($urandom_range(25));
    endcase
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(3))
      0: return CH_ADD;
      1: return CH_SUB;
      2: return CH_MUL;
      default: return CH_DIV;
    endcase
  endfunction

  // A space or one of the control characters from tab to carriage return.
  function automatic logic [7:0] random_blank();
    int k;
    k = $urandom_range(5);
    return (k == 0) ? CH_SPACE : CH_TAB + 8'(k - 1);
  endfunction

  // Builds a well-formed expression; a broken one has one character replaced, a ')' inserted or a character deleted.
  function automatic void build_expression(input bit broken);
    int n_operands;
    int open_cnt;
    int pos;
    infix_text.delete();
    open_cnt = 0;
    n_operands = $urandom_range(1, 8);
    for (int k = 0; k < n_operands; k++) begin
      while ($urandom_range(3) == 0) begin
        infix_text.push_back(CH_OPEN);
        open_cnt++;
      end
      infix_text.push_back(random_operand());
      while (open_cnt > 0 && $urandom_range(2) == 0) begin
        infix_text.push_back(CH_CLOSE);
        open_cnt--;
      end
      if (k != n_operands - 1) infix_text.push_back(random_operator());
      if ($urandom_range(9) == 0) infix_text.push_back(random_blank());
    end
    while (open_cnt > 0) begin
      infix_text.push_back(CH_CLOSE);
      open_cnt--;
    end
    if (broken) begin
      pos = $urandom_range(infix_text.size() - 1);
      case ($urandom_range(2))
        0: infix_text[pos] = 8'($urandom_range(255));
        1: infix_text.insert(pos, CH_CLOSE);
        default: if (infix_text.size() > 1) infix_text.delete(pos);
      endcase
    end
  endfunction

  // Deep nesting that can run past the stack depth.
  function automatic void build_deep();
    int units;
    infix_text.delete();
    units = $urandom_range(14, 20);
    repeat (units) begin
      infix_text.push_back(CH_OPEN);
      infix_text.push_back(random_operand());
      infix_text.push_back(random_operator());
    end
    infix_text.push_back(random_operand());
    repeat ($urandom_range(units)) infix_text.push_back(CH_CLOSE);
  endfunction

  task automatic send_text();
    foreach (infix_text[i]) offer(infix_text[i], i == infix_text.size() - 1, 1'b0, '0);
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 12);
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_postfix.size() == 0) begin
        $error("unexpected result: out_symbol %h error_code %0d",
               out_data.out_symbol, out_data.error_code);
        mismatches++;
      end else begin
        want = pending_postfix.pop_front();
        if (out_data.out_symbol !== want.out_symbol) begin
          $error("out_symbol: expected %h, actual %h", want.out_symbol, out_data.out_symbol);
          mismatches++;
        end
        if (out_data.has_symbol !== want.has_symbol) begin
          $error("has_symbol: expected %b, actual %b", want.has_symbol, out_data.has_symbol);
          mismatches++;
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %b, actual %b", want.last_of_run,
                 out_data.last_of_run);
          mismatches++;
        end
        if (out_data.error_code !== want.error_code) begin
          $error("error_code: expected %0d, actual %0d", want.error_code,
                 out_data.error_code);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int  seq_no;
    int  pick;
    bit  held;
    bit  drained;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    pile_size = 0;
    mismatches = 0;
    calm = 1'b0;
    hold_request = 1'b0;
    held = 1'b0;
    drained = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      offer(directed_rows[i].sym, directed_rows[i].eoe, directed_rows[i].typed,
            directed_rows[i].res);

    random_sent = 0;
    seq_no = 0;
    while (random_sent < RANDOM_ITEMS) begin
      calm = random_sent >= 250 && random_sent < 350;
      if (!held && random_sent >= 100) begin
        hold_request = 1'b1;
        held = 1'b1;
      end
      // Let the converter drain completely before the next transfer.
      if (((!drained && random_sent >= 200) || $urandom_range(24) == 0) &&
          pending_postfix.size() != 0) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        while (pending_postfix.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(99);
      if (seq_no == 0 || pick < 8) begin
        build_deep();
        send_text();
      end else if (pick < 20) begin
        repeat ($urandom_range(1, 8))
          offer(8'($urandom_range(255)), $urandom_range(7) == 0, 1'b0, '0);
      end else begin
        build_expression(pick < 30);
        send_text();
      end
      seq_no++;
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (pending_postfix.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
